[rtl/positional_list_store_assert.svh]
// Assertion helpers shared by the list store modules.
// Each expects clk and rst_n in scope.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pls_pkg.sv]
`timescale 1ns / 1ps
package pls_pkg;

  localparam int DEPTH_DEF = 256;

  // Word widths; the stream words are padded to whole bytes
  localparam int IN_W  = 48;
  localparam int OUT_W = 48;
  localparam int VAL_W = 32;
  localparam int POS_W = 9;
  localparam int ECNT_W = 9;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_READ,
    CMD_SEARCH
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BADPOS,
    ST_FULL,
    ST_EMPTY
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic put;
    logic finish;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic plan_walk;
    logic plan_put;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[rtl/positional_list_store.sv]
`timescale 1ns / 1ps
// Positional list store: an ordered list of up to DEPTH signed 32-bit
// entries, addressed by 1-based position. Each input word carries a
// command (insert, remove, read, search) and yields exactly one output
// word with the value read, a found flag, a status, the entry count after
// the command and an empty flag. Items are handled one at a time; the
// engine walks the entry RAM through its single registered read port, one
// entry per cycle. An insert adds a write step after its walk; insert
// walks count - position + 1 entries, remove count - position, read one
// and search count. An insert at the end skips the walk; removing the
// last entry or any refused command neither walks nor writes. A finished
// word waits in the output register while the next input word is taken.
// No clearing pass is needed after reset: only positions 1..count are
// ever read.
module positional_list_store #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command[1:0], position[10:2], item_value[42:11], zero fill
  input  logic [pls_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // read_value[31:0], found[32], status[34:33], entry_count[43:35],
  // is_empty[44], zero fill
  output logic [pls_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready
);

  pls_pkg::ctl_t cmd;
  pls_pkg::sts_t sts;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/pls_datapath.sv]
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"
module pls_datapath #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pls_pkg::IN_W-1:0] in_tdata,
  input  pls_pkg::ctl_t            cmd,
  output pls_pkg::sts_t            sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [pls_pkg::OUT_W-1:0] out_tdata
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W) + 1;

  // Entry storage
  logic [pls_pkg::VAL_W-1:0] mem [DEPTH];
  logic [pls_pkg::VAL_W-1:0] q_r;

  // Command context
  pls_pkg::cmd_t             cmd_r;
  logic [pls_pkg::VAL_W-1:0] val_r;
  logic [ADDR_W-1:0]         at_r;
  logic [ADDR_W-1:0]         ptr_r;
  logic [ADDR_W-1:0]         end_r;
  logic [ADDR_W-1:0]         wt_r;
  logic                      dn_r;
  logic                      inc_r;
  logic                      dec_r;
  logic                      pend_r;
  pls_pkg::status_t          st_r;
  logic                      found_r;
  logic [pls_pkg::VAL_W-1:0] rdv_r;
  logic [CNT_W-1:0]          count_r;
  logic                      out_valid_r;
  logic [pls_pkg::OUT_W-1:0] out_data_r;

  // Input word unpack
  pls_pkg::cmd_t             cmd_in;
  logic [pls_pkg::POS_W-1:0] pos_in;
  logic [pls_pkg::VAL_W-1:0] val_in;

  assign cmd_in = pls_pkg::cmd_t'(in_tdata[1:0]);
  assign pos_in = in_tdata[10:2];
  assign val_in = in_tdata[42:11];

  // Range checks and walk plan for the incoming word
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic [ADDR_W-1:0] at_in;
  logic [ADDR_W-1:0] clast;
  logic              full;
  logic              empty;
  logic              pos_zero;
  pls_pkg::status_t  st_in;
  logic              walk_in;
  logic              put_in;
  logic              dn_in;
  logic              inc_in;
  logic              dec_in;
  logic [ADDR_W-1:0] ptr_in;
  logic [ADDR_W-1:0] end_in;

  assign pos_x    = CMP_W'(pos_in);
  assign cnt_x    = CMP_W'(count_r);
  assign at_in    = ADDR_W'(pos_x - CMP_W'(1));
  assign clast    = ADDR_W'(cnt_x - CMP_W'(1));
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pos_zero = (pos_in == '0);

  always_comb begin
    st_in   = pls_pkg::ST_OK;
    walk_in = 1'b0;
    put_in  = 1'b0;
    dn_in   = 1'b0;
    inc_in  = 1'b0;
    dec_in  = 1'b0;
    ptr_in  = '0;
    end_in  = '0;
    unique case (cmd_in)
      pls_pkg::CMD_INSERT: begin
        if (full) begin
          st_in = pls_pkg::ST_FULL;
        end else if (pos_zero || pos_x > cnt_x + CMP_W'(1)) begin
          st_in = pls_pkg::ST_BADPOS;
        end else begin
          put_in = 1'b1;
          inc_in = 1'b1;
          // shift the tail up, last entry first
          if (pos_x <= cnt_x) begin
            walk_in = 1'b1;
            dn_in   = 1'b1;
            ptr_in  = clast;
            end_in  = at_in;
          end
        end
      end
      pls_pkg::CMD_REMOVE, pls_pkg::CMD_READ: begin
        if (empty) begin
          st_in = pls_pkg::ST_EMPTY;
        end else if (pos_zero || pos_x > cnt_x) begin
          st_in = pls_pkg::ST_BADPOS;
        end else if (cmd_in == pls_pkg::CMD_READ) begin
          walk_in = 1'b1;
          ptr_in  = at_in;
          end_in  = at_in;
        end else begin
          dec_in = 1'b1;
          // shift the tail down unless the last entry goes
          if (at_in != clast) begin
            walk_in = 1'b1;
            ptr_in  = ADDR_W'(at_in + ADDR_W'(1));
            end_in  = clast;
          end
        end
      end
      pls_pkg::CMD_SEARCH: begin
        if (empty) begin
          st_in = pls_pkg::ST_EMPTY;
        end else begin
          walk_in = 1'b1;
          ptr_in  = '0;
          end_in  = clast;
        end
      end
      default: st_in = pls_pkg::ST_OK;
    endcase
  end

  // Status to controller
  assign sts.plan_walk = walk_in;
  assign sts.plan_put  = put_in;
  assign sts.last      = (ptr_r == end_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  // Memory: registered read at the walk pointer, one write port
  logic shift_wr;
  assign shift_wr = pend_r && (cmd_r == pls_pkg::CMD_INSERT || cmd_r == pls_pkg::CMD_REMOVE);

  always_ff @(posedge clk) begin
    q_r <= mem[ptr_r];
    if (cmd.put) begin
      mem[at_r] <= val_r;
    end else if (shift_wr) begin
      mem[wt_r] <= q_r;
    end
  end

  // Context, walk pointer and result accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= cmd_in;
      val_r   <= val_in;
      at_r    <= at_in;
      ptr_r   <= ptr_in;
      end_r   <= end_in;
      dn_r    <= dn_in;
      inc_r   <= inc_in;
      dec_r   <= dec_in;
      st_r    <= st_in;
      found_r <= 1'b0;
      rdv_r   <= '0;
    end else begin
      if (cmd.walk) begin
        ptr_r <= dn_r ? ADDR_W'(ptr_r - ADDR_W'(1)) : ADDR_W'(ptr_r + ADDR_W'(1));
        wt_r  <= dn_r ? ADDR_W'(ptr_r + ADDR_W'(1)) : ADDR_W'(ptr_r - ADDR_W'(1));
      end
      if (pend_r && cmd_r == pls_pkg::CMD_SEARCH && q_r == val_r) begin
        found_r <= 1'b1;
      end
      if (pend_r && cmd_r == pls_pkg::CMD_READ) begin
        rdv_r <= q_r;
      end
    end
  end

  // Count and output register
  logic [CNT_W-1:0] count_new;
  assign count_new = CNT_W'(count_r + CNT_W'(inc_r) - CNT_W'(dec_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.walk;
      if (cmd.finish) begin
        count_r     <= count_new;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= {3'b000, (count_new == '0), pls_pkg::ECNT_W'(count_new), st_r,
                     found_r, rdv_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PLS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `PLS_ASSERT_NXT(a_count_hold, !cmd.finish, $stable(count_r), "count moved outside finish")
  `PLS_ASSERT_NXT(a_result_up, cmd.finish, out_valid_r, "finished word not presented")
  `PLS_ASSERT_IMP(a_one_write, cmd.put, !shift_wr, "put collides with shift write")

endmodule

[rtl/pls_ctrl.sv]
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"
module pls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pls_pkg::sts_t sts,
  output pls_pkg::ctl_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_PUT,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   put_r;

  // Commands decoded from state
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_WALK:   cmd.walk   = 1'b1;
      S_DRAIN:  cmd.walk   = 1'b0;
      S_PUT:    cmd.put    = 1'b1;
      S_FINISH: cmd.finish = sts.out_free;
      default:  cmd        = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      put_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            put_r <= sts.plan_put;
            if (sts.plan_walk) begin
              state_r <= S_WALK;
            end else if (sts.plan_put) begin
              state_r <= S_PUT;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_WALK: begin
          if (sts.last) begin
            state_r <= S_DRAIN;
          end
        end
        // last read word is written back, compared or captured here
        S_DRAIN:  state_r <= put_r ? S_PUT : S_FINISH;
        S_PUT:    state_r <= S_FINISH;
        S_FINISH: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PLS_ASSERT_NXT(a_walk_end, state_r == S_WALK && sts.last, state_r == S_DRAIN, "walk overran")
  `PLS_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.walk, cmd.put, cmd.finish}), "commands overlap")
  `PLS_ASSERT_NXT(a_put_finish, state_r == S_PUT, state_r == S_FINISH, "put not followed by finish")

endmodule
